[hdl/ites_pkg.sv]
// Shared types, codes and constants of the infix token expression evaluator.
package ites_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int NUM_W      = 31;
   localparam int RESULT_W   = 32;
   localparam int CNT_W      = $clog2(DATA_WIDTH);

   typedef enum logic [2:0] {
      KIND_NUM = 3'd0,
      KIND_ADD = 3'd1,
      KIND_SUB = 3'd2,
      KIND_MUL = 3'd3,
      KIND_DIV = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      MOP_NONE = 2'd0,
      MOP_MUL  = 2'd1,
      MOP_DIV  = 2'd2
   } mop_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DIV0  = 2'd1,
      ST_ORDER = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]       token_kind;
      logic [NUM_W-1:0] number_value;
      logic             last_token;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] result_value;
      logic [1:0]                 status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load_tok;
      logic       term_load;
      logic       term_mul;
      logic       div_start;
      logic       div_step;
      logic       div_fix;
      logic       sum_update;
      logic       sum_sub;
      logic       clear;
      logic       out_load;
      status_type out_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] kind;
      logic       last;
      logic       num_zero;
      logic       div_last;
      logic       out_free;
   } dp_sts_type;

endpackage

[hdl/ites_dp.sv]
// Datapath: token register, sum and term accumulators, divider, result register.
module ites_dp import ites_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cmd_type    cmd,
   output dp_sts_type sts,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output rsp_type    rsp_payload
);

   logic [2:0]            tok_kind_ff;
   logic [NUM_W-1:0]      tok_num_ff;
   logic                  tok_last_ff;
   logic [DATA_WIDTH-1:0] sum_ff, sum_in;
   logic [DATA_WIDTH-1:0] term_ff, term_in;
   logic [DATA_WIDTH-1:0] rem_ff, quo_ff, dvs_ff;
   logic                  neg_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [DATA_WIDTH-1:0] num_ext;
   logic [DATA_WIDTH-1:0] combined;
   logic [DATA_WIDTH:0]   shifted, diff;
   logic                  q_bit;

   assign num_ext  = DATA_WIDTH'(tok_num_ff);
   assign combined = cmd.sum_sub ? (sum_ff - term_ff) : (sum_ff + term_ff);

   // one restoring step: shift in the next dividend bit, try the subtract
   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign q_bit   = ~diff[DATA_WIDTH];

   always_comb begin
      term_in = term_ff;
      if (cmd.clear) begin
         term_in = '0;
      end else if (cmd.term_load) begin
         term_in = num_ext;
      end else if (cmd.term_mul) begin
         term_in = term_ff * num_ext;
      end else if (cmd.div_fix) begin
         term_in = neg_ff ? (DATA_WIDTH'(0) - quo_ff) : quo_ff;
      end
      sum_in = sum_ff;
      if (cmd.clear) begin
         sum_in = '0;
      end else if (cmd.sum_update) begin
         sum_in = combined;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         term_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         term_ff <= term_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.load_tok) begin
         tok_kind_ff <= req_payload.token_kind;
         tok_num_ff  <= req_payload.number_value;
         tok_last_ff <= req_payload.last_token;
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= term_ff[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - term_ff) : term_ff;
         dvs_ff <= num_ext;
         neg_ff <= term_ff[DATA_WIDTH-1];
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
         quo_ff <= {quo_ff[DATA_WIDTH-2:0], q_bit};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.out_load) begin
         rsp_ff.status       <= cmd.out_status;
         rsp_ff.result_value <= (cmd.out_status == ST_OK) ? RESULT_W'($signed(combined)) : '0;
      end
   end

   assign sts.kind     = tok_kind_ff;
   assign sts.last     = tok_last_ff;
   assign sts.num_zero = (num_ext == '0);
   assign sts.div_last = (cnt_ff == CNT_W'(DATA_WIDTH - 1));
   assign sts.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hdl/ites_ctrl.sv]
// Controller: token sequencing, precedence state, error tracking.
module ites_ctrl import ites_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_DFIX,
      S_FIN
   } state_type;

   state_type  state_ff, state_in;
   status_type err_ff, err_in;
   logic       expect_ff, expect_in;
   mop_type    mop_ff, mop_in;
   logic       sub_ff, sub_in;

   always_comb begin
      state_in  = state_ff;
      err_in    = err_ff;
      expect_in = expect_ff;
      mop_in    = mop_ff;
      sub_in    = sub_ff;
      cmd       = '0;
      cmd.out_status = ST_OK;
      cmd.sum_sub    = sub_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_tok = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            if (err_ff == ST_OK) begin
               unique case (kind_type'(sts.kind)) inside
                  KIND_NUM: begin
                     if (!expect_ff) begin
                        err_in = ST_ORDER;
                     end else if (mop_ff == MOP_MUL) begin
                        cmd.term_mul = 1'b1;
                        expect_in    = 1'b0;
                     end else if (mop_ff == MOP_DIV) begin
                        if (sts.num_zero) begin
                           err_in = ST_DIV0;
                        end else begin
                           cmd.div_start = 1'b1;
                           expect_in     = 1'b0;
                           state_in      = S_DIV;
                        end
                     end else begin
                        cmd.term_load = 1'b1;
                        expect_in     = 1'b0;
                     end
                  end
                  KIND_ADD, KIND_SUB: begin
                     if (expect_ff) begin
                        err_in = ST_ORDER;
                     end else begin
                        cmd.sum_update = 1'b1;
                        sub_in    = (kind_type'(sts.kind) == KIND_SUB);
                        mop_in    = MOP_NONE;
                        expect_in = 1'b1;
                     end
                  end
                  KIND_MUL, KIND_DIV: begin
                     if (expect_ff) begin
                        err_in = ST_ORDER;
                     end else begin
                        mop_in    = (kind_type'(sts.kind) == KIND_DIV) ? MOP_DIV : MOP_MUL;
                        expect_in = 1'b1;
                     end
                  end
                  default: err_in = ST_ORDER;
               endcase
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DFIX;
            end
         end
         S_DFIX: begin
            cmd.div_fix = 1'b1;
            state_in    = S_FIN;
         end
         S_FIN: begin
            if (!sts.last) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = (err_ff != ST_OK) ? err_ff :
                                (expect_ff ? ST_ORDER : ST_OK);
               cmd.clear = 1'b1;
               err_in    = ST_OK;
               expect_in = 1'b1;
               mop_in    = MOP_NONE;
               sub_in    = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         err_ff    <= ST_OK;
         expect_ff <= 1'b1;
         mop_ff    <= MOP_NONE;
         sub_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         err_ff    <= err_in;
         expect_ff <= expect_in;
         mop_ff    <= mop_in;
         sub_ff    <= sub_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_out_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (sts.out_free && sts.last && state_ff == S_FIN))
      else $error("result loaded while output register busy");
   a_div_enters_loop: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == S_DIV))
      else $error("divider started without entering divide loop");
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && state_ff != S_FIN) |=> (err_ff == $past(err_ff)))
      else $error("recorded error changed before end of expression");
   a_clear_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (err_ff == ST_OK && expect_ff && mop_ff == MOP_NONE))
      else $error("state not cleared after final item");
`endif

endmodule

[hdl/infix_token_expression_evaluator_unit.sv]
// Top level of the two-level precedence integer expression evaluator.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    req_type: token_kind, number_value, last_token
//   rsp_     out        rsp_valid/rsp_ready    rsp_type: result_value, status
//
// An item passes through accept, execute and finish states; a number that follows a
// divide also passes through the shared restoring divider, which retires one quotient
// bit per cycle, and then through a sign fix-up state before finish.
// Reset (synchronous, active high) clears the accumulators and precedence
// state so that a number is expected. The result sits in an output register:
// new items are taken while it waits, and only a final item stalls in its
// finish cycle until that register frees up.
module infix_token_expression_evaluator_unit import ites_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   dp_sts_type sts;

   // sequence each item and track operator order and errors
   ites_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold the accumulators, run multiply and divide, register the result
   ites_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

[tb/tb.sv]
// Self-checking testbench of the infix token expression evaluator.
module tb;
   import ites_pkg::*;

   localparam logic [2:0] KIND_RESERVED_TOP = 3'd7;
   localparam int RANDOM_TOKENS = 1400;
   localparam int CALM_FROM     = 500;    // token counts bounding the no-idle stretch
   localparam int CALM_TO       = 800;
   localparam int HOLD_AFTER    = 300;    // tokens accepted before the long receiver stall
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 80;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // evaluator state as predicted
   logic [31:0] sum_acc          = '0;
   logic        subtract_pending = 1'b0;
   logic [31:0] term_acc         = '0;
   mop_type     mul_pending      = MOP_NONE;
   logic        want_number      = 1'b1;
   status_type  fault            = ST_OK;

   req_type token_queue[$];
   rsp_type pending_results[$];
   int      tokens_queued   = 0;
   int      tokens_accepted = 0;
   int      results_checked = 0;
   int      mismatch_count  = 0;
   int      status_seen[3]  = '{0, 0, 0};
   logic    hold_off        = 1'b0;

   infix_token_expression_evaluator_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Advance the predicted state by one accepted token; queue a result on the last one.
   task automatic evaluate_token(input req_type tok);
      logic [31:0] num;
      logic [31:0] total;
      rsp_type     res;
      num = {1'b0, tok.number_value};
      if (fault == ST_OK) begin
         case (tok.token_kind) inside
            KIND_NUM: begin
               if (!want_number) begin
                  fault = ST_ORDER;
               end else if (mul_pending == MOP_MUL) begin
                  term_acc    = term_acc * num;
                  want_number = 1'b0;
               end else if (mul_pending == MOP_DIV) begin
                  if (num == '0) begin
                     fault = ST_DIV0;
                  end else begin
                     // signed division truncates toward zero
                     term_acc    = $signed(term_acc) / $signed(num);
                     want_number = 1'b0;
                  end
               end else begin
                  term_acc    = num;
                  want_number = 1'b0;
               end
            end
            KIND_ADD, KIND_SUB: begin
               if (want_number) begin
                  fault = ST_ORDER;
               end else begin
                  sum_acc          = subtract_pending ? sum_acc - term_acc : sum_acc + term_acc;
                  subtract_pending = (tok.token_kind == KIND_SUB);
                  mul_pending      = MOP_NONE;
                  want_number      = 1'b1;
               end
            end
            KIND_MUL, KIND_DIV: begin
               if (want_number) begin
                  fault = ST_ORDER;
               end else begin
                  mul_pending = (tok.token_kind == KIND_DIV) ? MOP_DIV : MOP_MUL;
                  want_number = 1'b1;
               end
            end
            default: begin
               fault = ST_ORDER;
            end
         endcase
      end
      if (tok.last_token) begin
         if (fault == ST_OK && want_number) fault = ST_ORDER;
         total = subtract_pending ? sum_acc - term_acc : sum_acc + term_acc;
         res.result_value = (fault == ST_OK) ? total : '0;
         res.status       = fault;
         pending_results  = {pending_results, res};
         status_seen[fault]++;
         sum_acc          = '0;
         subtract_pending = 1'b0;
         term_acc         = '0;
         mul_pending      = MOP_NONE;
         want_number      = 1'b1;
         fault            = ST_OK;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result %0d status %0d with nothing outstanding",
                                   got.result_value, got.status));
      end else begin
         want = pending_results.pop_front();
         results_checked++;
         if (got.result_value !== want.result_value)
            report_mismatch($sformatf("result_value %0d, expected %0d",
                                      got.result_value, want.result_value));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
   endtask

   function automatic bit calm();
      return tokens_accepted >= CALM_FROM && tokens_accepted < CALM_TO;
   endfunction

   function automatic bit take_break();
      return !calm() && ($urandom_range(99) < 9);
   endfunction

   function automatic logic [30:0] pick_number();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(19))
         0:       return '0;
         1:       return 31'h7fff_ffff;
         2:       return 31'(31'h7fff_ffff - $urandom_range(15));
         3, 4, 5: return 31'($urandom_range(1, 9));
         6, 7, 8: return 31'($urandom_range(1, 1000));
         default: return r[30:0];
      endcase
   endfunction

   task automatic queue_token(input logic [2:0] kind, input logic [30:0] value, input bit last);
      req_type t;
      t.token_kind   = kind;
      t.number_value = value;
      t.last_token   = last;
      token_queue    = {token_queue, t};
   endtask

   // Build one expression of alternating numbers and operators; a corrupt one
   // gets a random kind at one place and may lose its closing number.
   task automatic queue_expression(input int numbers, input bit corrupt);
      req_type seq[$];
      req_type t;
      int      pos;
      for (int i = 0; i < numbers; i++) begin
         if (i != 0) begin
            t.token_kind   = 3'($urandom_range(KIND_ADD, KIND_DIV));
            t.number_value = 31'($urandom());
            t.last_token   = 1'b0;
            seq            = {seq, t};
         end
         t.token_kind   = KIND_NUM;
         t.number_value = pick_number();
         t.last_token   = 1'b0;
         seq            = {seq, t};
      end
      if (corrupt) begin
         pos = $urandom_range(seq.size() - 1);
         seq[pos].token_kind = 3'($urandom_range(KIND_RESERVED_TOP));
         if (seq.size() > 1 && $urandom_range(2) == 0) void'(seq.pop_back());
      end
      seq[seq.size() - 1].last_token = 1'b1;
      foreach (seq[i]) token_queue = {token_queue, seq[i]};
   endtask

   // Driver: hold the item until taken, then offer the next one or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            evaluate_token(req_payload);
            tokens_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (token_queue.size() != 0 && !take_break()) begin
               req_payload <= token_queue.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check every result taken, stall now and then.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_payload);
         rsp_ready <= !hold_off && !take_break();
      end
   end

   // Long receiver stall while the sender keeps offering tokens.
   initial begin
      while (tokens_accepted < HOLD_AFTER) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #4_000_000;
      $display("run timed out with %0d of %0d tokens taken, %0d results outstanding",
               tokens_accepted, tokens_queued, pending_results.size());
      $display("FAILURE");
      $finish;
   end

   initial begin
      int directed;
      // precedence, wrapping product, truncating division of a negative term
      queue_token(KIND_NUM, 31'd9, 1'b0);
      queue_token(KIND_SUB, '0, 1'b0);
      queue_token(KIND_NUM, 31'h7fff_ffff, 1'b0);
      queue_token(KIND_MUL, '0, 1'b0);
      queue_token(KIND_NUM, 31'd4, 1'b0);
      queue_token(KIND_DIV, '0, 1'b0);
      queue_token(KIND_NUM, 31'd3, 1'b0);
      queue_token(KIND_ADD, 31'h7fff_ffff, 1'b0);
      queue_token(KIND_NUM, '0, 1'b1);
      // sum wraps to the most negative value
      queue_token(KIND_NUM, 31'h7fff_ffff, 1'b0);
      queue_token(KIND_ADD, '0, 1'b0);
      queue_token(KIND_NUM, 31'd1, 1'b1);
      // divide by zero, then a misplaced operator that must not override it
      queue_token(KIND_NUM, 31'd6, 1'b0);
      queue_token(KIND_DIV, '0, 1'b0);
      queue_token(KIND_NUM, '0, 1'b0);
      queue_token(KIND_ADD, '0, 1'b1);
      // lone operator
      queue_token(KIND_ADD, '0, 1'b1);
      // number after number
      queue_token(KIND_NUM, 31'd3, 1'b0);
      queue_token(KIND_NUM, 31'd3, 1'b1);
      // leading operator
      queue_token(KIND_SUB, '0, 1'b0);
      queue_token(KIND_NUM, 31'd3, 1'b1);
      // two operators in a row
      queue_token(KIND_NUM, 31'd3, 1'b0);
      queue_token(KIND_MUL, '0, 1'b0);
      queue_token(KIND_DIV, '0, 1'b1);
      // reserved token kind
      queue_token(KIND_NUM, 31'd1, 1'b0);
      queue_token(KIND_RESERVED_TOP, 31'h7fff_ffff, 1'b1);
      // expression ends on an operator
      queue_token(KIND_NUM, 31'd4, 1'b0);
      queue_token(KIND_ADD, '0, 1'b1);
      directed = token_queue.size();

      // mostly well-formed expressions, some corrupted
      while (token_queue.size() < directed + RANDOM_TOKENS)
         queue_expression(($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5),
                          $urandom_range(99) < 12);
      tokens_queued = token_queue.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (tokens_accepted < tokens_queued) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      $display("covered %0d tokens in %0d expressions, receiver stalled %0d cycles once",
               tokens_accepted, results_checked, HOLD_CYCLES);
      $display("outcomes: %0d evaluated, %0d divide by zero, %0d bad token order",
               status_seen[ST_OK], status_seen[ST_DIV0], status_seen[ST_ORDER]);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
